// ===== sv/qrs_pkg.sv =====
// ============================================================================
// qrs_pkg: shared types and constants for the quadratic root solver
// Root kinds, stage widths and the control words carried down the pipeline.
// ============================================================================
package qrs_pkg;

  localparam int COEF_W     = 16;
  localparam int KIND_W     = 2;
  localparam int ROOT_W     = 34;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;

  // square root: 33 result bits, one per stage
  localparam int SQ_STEPS = 33;
  localparam int SQ_REM_W = 35;
  localparam int RAD_W    = 34;

  localparam int NB_W  = 33;
  localparam int DEN_W = 17;
  localparam int NUM_W = 35;

  // divider: 34 quotient bits, one per stage
  localparam int DV_STEPS = 34;
  localparam int DV_W     = DEN_W + DV_STEPS;

  typedef enum logic [KIND_W-1:0] {
    KIND_REAL      = 2'd0,
    KIND_COMPLEX   = 2'd1,
    KIND_ZERO_LEAD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    a_neg;
    logic signed [NB_W-1:0]  nb;
    logic [DEN_W-1:0]        den;
  } sq_ctl_t;

  typedef struct packed {
    kind_t            kind;
    logic             neg0;
    logic             neg1;
    logic [DEN_W-1:0] den;
  } dv_ctl_t;

endpackage

// ===== sv/quadratic_root_solver.sv =====
// ============================================================================
// quadratic_root_solver: roots of a*x^2 + b*x + c in signed Q18.16
// Discriminant, bit-per-stage square root and two bit-per-stage dividers.
// ============================================================================
//
//  channel | ports                      | word
//  --------+----------------------------+-------------------------------------
//  in      | in_tvalid/tready/tdata     | coef_square, coef_linear, coef_constant
//  out     | out_tvalid/tready/tdata/tuser | first_real, second_real, imag_part;
//          |                            | tuser = root_kind
//
//  One word per cycle while the output does not stall. Each result passes 2
//  discriminant stages (the first loads on the edge that takes its input), 33
//  square-root stages, 1 numerator stage, 34 divider stages, then the output register.
//  A stalled output freezes the whole pipeline; a skid register takes one more
//  input word while the output waits, and in_tready stays low while that word
//  sits in the skid register, until it moves on after the stall.
//  Reset (rst_n low, synchronous) empties every stage and the skid register.
//
module quadratic_root_solver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coef_square[15:0], coef_linear[31:16], coef_constant[47:32]
  input  logic [qrs_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // first_real[33:0], second_real[67:34], imag_part[101:68], zero pad
  output logic [qrs_pkg::OUT_DATA_W-1:0]   out_tdata,
  // root_kind[1:0]
  output logic [qrs_pkg::KIND_W-1:0]       out_tuser
);
  import qrs_pkg::*;

  logic                        en;
  logic                        skid_v_r;
  logic [IN_DATA_W-1:0]        skid_data_r;
  logic                        src_v;
  logic [IN_DATA_W-1:0]        src_data;
  logic signed [COEF_W-1:0]    src_a;
  logic signed [COEF_W-1:0]    src_b;
  logic signed [COEF_W-1:0]    src_c;

  logic                        st1_v_r;
  logic signed [COEF_W-1:0]    a_r;
  logic signed [COEF_W-1:0]    b_r;
  logic signed [31:0]          bb_r;
  logic signed [31:0]          ac_r;

  logic [33:0]                 disc;
  logic [RAD_W-1:0]            disc_mag;
  logic [COEF_W-1:0]           a_mag;
  logic [COEF_W:0]             neg_b;
  sq_ctl_t                     sq_ctl_nxt;

  logic                        sq_v_r    [0:SQ_STEPS];
  logic [SQ_REM_W-1:0]         sq_rem_r  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0]         sq_root_r [0:SQ_STEPS];
  logic [RAD_W-1:0]            sq_rad_r  [0:SQ_STEPS];
  sq_ctl_t                     sq_ctl_r  [0:SQ_STEPS];

  sq_ctl_t                     sq_last;
  logic [NUM_W-1:0]            nb_ext;
  logic [NUM_W-1:0]            s_ext;
  logic [NUM_W-1:0]            num0;
  logic [NUM_W-1:0]            num1;
  logic [NUM_W-1:0]            mag0;
  logic [NUM_W-1:0]            mag1;
  dv_ctl_t                     dv_ctl_nxt;

  logic                        dv_v_r   [0:DV_STEPS];
  dv_ctl_t                     dv_ctl_r [0:DV_STEPS];
  logic [DV_W-1:0]             dv_wk_r  [0:1][0:DV_STEPS];

  dv_ctl_t                     dv_last;
  logic [ROOT_W-1:0]           q0;
  logic [ROOT_W-1:0]           q1;
  logic [ROOT_W-1:0]           q0_s;
  logic [ROOT_W-1:0]           q1_s;
  logic [ROOT_W-1:0]           first_nxt;
  logic [ROOT_W-1:0]           second_nxt;
  logic [ROOT_W-1:0]           imag_nxt;

  logic                        out_tvalid_r;
  logic [OUT_DATA_W-1:0]       out_data_r;
  logic [KIND_W-1:0]           out_kind_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = !skid_v_r;

  // input skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_v_r && in_tvalid) begin
      skid_data_r <= in_tdata;
    end
  end

  assign src_v    = skid_v_r || in_tvalid;
  assign src_data = skid_v_r ? skid_data_r : in_tdata;
  assign src_a    = src_data[15:0];
  assign src_b    = src_data[31:16];
  assign src_c    = src_data[47:32];

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (en) begin
      st1_v_r <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= src_a;
      b_r  <= src_b;
      bb_r <= 32'(src_b) * 32'(src_b);
      ac_r <= 32'(src_a) * 32'(src_c);
    end
  end

  // stage 2: discriminant, -b*2^16, |2a|
  always_comb begin
    disc     = {{2{bb_r[31]}}, bb_r} - {ac_r, 2'b00};
    disc_mag = disc[33] ? (34'd0 - disc) : disc;
    a_mag    = a_r[15] ? (16'd0 - a_r) : a_r;
    neg_b    = 17'd0 - {b_r[15], b_r};
    sq_ctl_nxt.a_neg = a_r[15];
    sq_ctl_nxt.nb    = {neg_b, 16'h0000};
    sq_ctl_nxt.den   = {a_mag, 1'b0};
    if (a_r == '0) begin
      sq_ctl_nxt.kind = KIND_ZERO_LEAD;
    end else if (disc[33]) begin
      sq_ctl_nxt.kind = KIND_COMPLEX;
    end else begin
      sq_ctl_nxt.kind = KIND_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= st1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= disc_mag;
      sq_ctl_r[0]  <= sq_ctl_nxt;
    end
  end

  // square root of |d|*2^32, two radicand bits per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [SQ_REM_W+1:0] rem_sh;
    logic [SQ_REM_W+1:0] trial;
    logic                take;

    assign rem_sh = {sq_rem_r[k], sq_rad_r[k][RAD_W-1 -: 2]};
    assign trial  = {2'b00, sq_root_r[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= take ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
        sq_root_r[k+1] <= {sq_root_r[k][SQ_STEPS-2:0], take};
        sq_rad_r[k+1]  <= {sq_rad_r[k][RAD_W-3:0], 2'b00};
        sq_ctl_r[k+1]  <= sq_ctl_r[k];
      end
    end
  end

  // numerators and quotient signs
  always_comb begin
    sq_last = sq_ctl_r[SQ_STEPS];
    nb_ext  = {{(NUM_W-NB_W){sq_last.nb[NB_W-1]}}, sq_last.nb};
    s_ext   = {{(NUM_W-SQ_STEPS){1'b0}}, sq_root_r[SQ_STEPS]};
    if (sq_last.kind == KIND_REAL) begin
      num0 = nb_ext + s_ext;
      num1 = nb_ext - s_ext;
    end else begin
      num0 = nb_ext;
      num1 = s_ext;
    end
    mag0 = num0[NUM_W-1] ? (NUM_W'(0) - num0) : num0;
    mag1 = num1[NUM_W-1] ? (NUM_W'(0) - num1) : num1;
    dv_ctl_nxt.kind = sq_last.kind;
    dv_ctl_nxt.neg0 = num0[NUM_W-1] ^ sq_last.a_neg;
    dv_ctl_nxt.neg1 = num1[NUM_W-1] ^ sq_last.a_neg;
    dv_ctl_nxt.den  = sq_last.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0]   <= dv_ctl_nxt;
      dv_wk_r[0][0] <= {{DEN_W{1'b0}}, mag0[DV_STEPS-1:0]};
      dv_wk_r[1][0] <= {{DEN_W{1'b0}}, mag1[DV_STEPS-1:0]};
    end
  end

  // restoring dividers, one quotient bit per stage; remainder on top of the word
  for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctl_r[k+1] <= dv_ctl_r[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W:0] rem_sh;
      logic [DEN_W:0] rem_new;
      logic           take;

      assign rem_sh  = dv_wk_r[l][k][DV_W-1:DV_STEPS-1];
      assign take    = rem_sh >= {1'b0, dv_ctl_r[k].den};
      assign rem_new = take ? (rem_sh - {1'b0, dv_ctl_r[k].den}) : rem_sh;

      always_ff @(posedge clk) begin
        if (en) begin
          dv_wk_r[l][k+1] <= {rem_new[DEN_W-1:0], dv_wk_r[l][k][DV_STEPS-2:0], take};
        end
      end
    end
  end

  // signs and field selection
  always_comb begin
    dv_last = dv_ctl_r[DV_STEPS];
    q0      = dv_wk_r[0][DV_STEPS][DV_STEPS-1:0];
    q1      = dv_wk_r[1][DV_STEPS][DV_STEPS-1:0];
    q0_s    = dv_last.neg0 ? (ROOT_W'(0) - q0) : q0;
    q1_s    = dv_last.neg1 ? (ROOT_W'(0) - q1) : q1;
    case (dv_last.kind)
      KIND_REAL: begin
        first_nxt  = q0_s;
        second_nxt = q1_s;
        imag_nxt   = '0;
      end
      KIND_COMPLEX: begin
        first_nxt  = q0_s;
        second_nxt = q0_s;
        imag_nxt   = q1_s;
      end
      default: begin
        first_nxt  = '0;
        second_nxt = '0;
        imag_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_v_r[DV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {{(OUT_DATA_W-3*ROOT_W){1'b0}}, imag_nxt, second_nxt, first_nxt};
      out_kind_r <= dv_last.kind;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// ===== sv/qrs_checker.sv =====
// ============================================================================
// qrs_checker: port-level checks for the quadratic root solver
// Output hold under stall and consistency of the result fields per kind.
// ============================================================================
module qrs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qrs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [qrs_pkg::KIND_W-1:0]      out_tuser
);
  import qrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_zero_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ZERO_LEAD |-> out_tdata == '0)
    else $error("zero leading coefficient with nonzero roots");

  a_real_imag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REAL |-> out_tdata[101:68] == '0)
    else $error("real roots with imaginary part");

  a_cplx_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_COMPLEX |->
      out_tdata[33:0] == out_tdata[67:34] && out_tdata[101:68] != '0)
    else $error("complex pair with unequal real parts or zero imaginary part");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ===== test/quadratic_root_solver_tb.sv =====
// ============================================================================
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// Drives a short table of directed equations and then random ones, with
// random gaps on the input and random stalls on the output. Every result
// word is compared, field by field, with an independently computed answer.
// ============================================================================
module quadratic_root_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qrs_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [ROOT_W-1:0] re0;
    logic [ROOT_W-1:0] re1;
    logic [ROOT_W-1:0] im;
  } roots_t;

  // typed rows carry their answer; the rest go through solve_roots
  typedef struct {
    bit     typed;
    int     a;
    int     b;
    int     c;
    kind_t  kind;
    longint re0;
    longint re1;
    longint im;
  } coef_row_t;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 430;
  localparam int LATENCY    = 70;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic                    out_tready = 1'b0;
  logic                    in_tready;
  logic                    out_tvalid;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [KIND_W-1:0]       out_tuser;

  roots_t    pending_roots[$];
  coef_row_t directed_rows[N_DIRECTED];
  int        mismatches = 0;
  bit        steady     = 1'b0;
  int        stall_left = 0;

  quadratic_root_solver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic roots_t solve_roots(logic signed [COEF_W-1:0] a,
                                         logic signed [COEF_W-1:0] b,
                                         logic signed [COEF_W-1:0] c);
    longint signed sa, sb, sc, disc, num, den, s;
    logic [RAD_W-1:0] mag;
    logic [69:0]      rad;
    logic [34:0]      root, trial;
    roots_t           r;
    r.kind = KIND_ZERO_LEAD;
    r.re0  = '0;
    r.re1  = '0;
    r.im   = '0;
    if (a == 0) return r;
    sa   = a;
    sb   = b;
    sc   = c;
    disc = sb * sb - 4 * sa * sc;
    mag  = (disc < 0) ? RAD_W'(-disc) : RAD_W'(disc);
    rad  = {4'b0, mag, 32'b0};
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      trial = root | (35'd1 << i);
      if (70'(trial) * 70'(trial) <= rad) root = trial;
    end
    s   = longint'(root);
    den = 2 * sa;
    num = -sb * 65536;
    if (disc >= 0) begin
      r.kind = KIND_REAL;
      r.re0  = ROOT_W'((num + s) / den);
      r.re1  = ROOT_W'((num - s) / den);
    end else begin
      r.kind = KIND_COMPLEX;
      r.re0  = ROOT_W'(num / den);
      r.re1  = ROOT_W'(num / den);
      r.im   = ROOT_W'(s / den);
    end
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_coefs(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                            input logic [COEF_W-1:0] c, input bit typed,
                            input roots_t given);
    int gap;
    in_tdata  <= {c, b, a};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_roots.push_back(typed ? given : solve_roots(a, b, c));
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pending();
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_out
    roots_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected word, tdata %h tuser %0d",
                                  out_tdata, out_tuser));
      end else begin
        want = pending_roots.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("root_kind got %0d expected %0d",
                                    out_tuser, want.kind));
        if (out_tdata[33:0] !== want.re0)
          report_mismatch($sformatf("first_real got %0d expected %0d",
                                    $signed(out_tdata[33:0]), $signed(want.re0)));
        if (out_tdata[67:34] !== want.re1)
          report_mismatch($sformatf("second_real got %0d expected %0d",
                                    $signed(out_tdata[67:34]), $signed(want.re1)));
        if (out_tdata[101:68] !== want.im)
          report_mismatch($sformatf("imag_part got %0d expected %0d",
                                    $signed(out_tdata[101:68]), $signed(want.im)));
      end
    end
  end

  initial begin
    int        a, b, c, r, t, pick, waited;
    roots_t    given;
    coef_row_t row;

    directed_rows = '{
      '{1'b1,      0,      0,      0, KIND_ZERO_LEAD, 0, 0, 0},
      '{1'b1,      0,  32767, -32768, KIND_ZERO_LEAD, 0, 0, 0},
      '{1'b1,      0, -32768,  32767, KIND_ZERO_LEAD, 0, 0, 0},
      '{1'b1,      1,      0,      0, KIND_REAL, 0, 0, 0},
      '{1'b1,      1,      0,     -1, KIND_REAL, 65536, -65536, 0},
      '{1'b1,      1,      0,      1, KIND_COMPLEX, 0, 0, 65536},
      '{1'b1,     -1,      0,      1, KIND_REAL, -65536, 65536, 0},
      '{1'b1,     -1,      0,     -1, KIND_COMPLEX, 0, 0, -65536},
      '{1'b1,      1,     -2,      1, KIND_REAL, 65536, 65536, 0},
      '{1'b1,      1, -32768,      0, KIND_REAL, 64'sd2147483648, 0, 0},
      '{1'b0,  32767,  32767,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0, -32768, -32768, -32768, KIND_REAL, 0, 0, 0},
      '{1'b0, -32768,  32767,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0,  32767, -32768, -32768, KIND_REAL, 0, 0, 0},
      '{1'b0,      1,  32767, -32768, KIND_REAL, 0, 0, 0},
      '{1'b0,     -1, -32768,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0,      1,      0,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0,  32767,      0,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0,      1,      1, -32768, KIND_REAL, 0, 0, 0},
      '{1'b0, -32768,      0,  32767, KIND_REAL, 0, 0, 0},
      '{1'b0,      3,      1,      0, KIND_REAL, 0, 0, 0},
      '{1'b0,     -3,     -1,      1, KIND_REAL, 0, 0, 0},
      '{1'b0,      2,      3,      2, KIND_REAL, 0, 0, 0},
      '{1'b0, -32768, -32768,  32767, KIND_REAL, 0, 0, 0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row        = directed_rows[i];
      given.kind = row.kind;
      given.re0  = ROOT_W'(row.re0);
      given.re1  = ROOT_W'(row.re1);
      given.im   = ROOT_W'(row.im);
      push_coefs(16'(row.a), 16'(row.b), 16'(row.c), row.typed, given);
    end
    drain_pending();

    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 150 && n < 250);
      if (n == 300) drain_pending();
      pick = $urandom_range(0, 99);
      a = $signed(16'($urandom()));
      b = $signed(16'($urandom()));
      c = $signed(16'($urandom()));
      if (pick >= 50 && pick < 65) begin
        a = int'($urandom_range(0, 40)) - 20;
        b = int'($urandom_range(0, 40)) - 20;
        c = int'($urandom_range(0, 40)) - 20;
      end else if (pick >= 65 && pick < 75) begin
        // double root: b*b == 4*a*c
        r = $urandom_range(1, 100);
        if ($urandom_range(0, 1) == 1) r = -r;
        t = int'($urandom_range(0, 30)) - 15;
        a = r;
        b = 2 * r * t;
        c = r * t * t;
      end else if (pick >= 75 && pick < 85) begin
        a = 0;
      end else if (pick >= 85 && pick < 95) begin
        case ($urandom_range(0, 3))
          0: a = 1;
          1: a = -1;
          2: a = 32767;
          default: a = -32768;
        endcase
      end else if (pick >= 95) begin
        b = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        a = int'($urandom_range(1, 8));
        c = int'($urandom_range(0, 16)) - 8;
      end
      push_coefs(16'(a), 16'(b), 16'(c), 1'b0, given);
    end
    steady    = 1'b0;
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_roots.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_roots.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_roots.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== quadratic_root_solver.f =====
sv/qrs_pkg.sv
sv/quadratic_root_solver.sv
sv/qrs_checker.sv
test/quadratic_root_solver_tb.sv
